>>> src/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the LRU key-value cache
// Entry count, field widths, and the structs that run along the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int CAP_W   = 5;
    localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    localparam logic [CAP_W-1:0]  CAP_RESET   = CAP_W'(16);
    localparam logic [CMP_W-1:0]  ENTRIES_CMP = CMP_W'(ENTRIES);
    localparam logic [DATA_W-1:0] MISS_VALUE  = {DATA_W{1'b1}};

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // passed from cell to cell
    typedef struct packed {
        logic              free_seen;
        logic              hit;
        logic [RANK_W-1:0] rank;
        logic [DATA_W-1:0] data;
    } chain_t;

    // broadcast to every cell
    typedef struct packed {
        logic              exec;
        logic              put;
        logic              hit;
        logic              fill;
        logic              evict;
        logic              age_all;
        logic [RANK_W-1:0] limit;
        logic [RANK_W-1:0] occ_m1;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
    } cmd_t;

endpackage

`default_nettype wire

>>> src/lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit: fully associative key-value cache, LRU replacement
//
// Request: start with action (0 get, 1 put), key and value. A request
// transfers on a clock edge with start high and busy low. busy is high for
// the one cycle in which the cell row compares the key and updates entries.
// Result: done pulses for one cycle with found and read_value, registered at
// the end of the compare and update pass. A new request may transfer in the
// same cycle as done; no request is taken while busy is high, so requests do
// not overlap in the cell row. There is no result stall: done is never held.
// Capacity: cfg_wr_en writes cfg_wr_data into the capacity register; write
// only while idle. A capacity of 0 acts as 1, above the entry count acts as
// the entry count.
// Reset: all entries invalid, occupancy zero, capacity 16, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_unit
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               action,
    input  wire logic signed [lkvc_pkg::KEY_W-1:0]  key,
    input  wire logic signed [lkvc_pkg::DATA_W-1:0] value,
    output logic                                    done,
    output logic                                    found,
    output logic signed [lkvc_pkg::DATA_W-1:0]      read_value,
    input  wire logic                               cfg_wr_en,
    input  wire logic [lkvc_pkg::CAP_W-1:0]         cfg_wr_data
);
    import lkvc_pkg::*;

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic              act_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] val_reg;
    logic              done_reg, done_next;
    logic              found_reg, found_next;
    logic [DATA_W-1:0] rdata_reg, rdata_next;

    logic              accept;
    logic              exec;
    logic              hit;
    logic              room;
    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  eff_cap;
    cmd_t              cmd;
    chain_t            chain [ENTRIES+1];

    assign accept = start && (state_reg == ST_IDLE);
    assign exec   = (state_reg == ST_EXEC);
    assign hit    = chain[ENTRIES].hit;

    always_comb
    begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > ENTRIES_CMP)
        begin
            eff_cap = ENTRIES_CMP;
        end
        else
        begin
            eff_cap = cap_ext;
        end
        room = CMP_W'(occ_reg) < eff_cap;
    end

    always_comb
    begin
        cmd.exec    = exec;
        cmd.put     = (act_reg == ACT_PUT);
        cmd.hit     = hit;
        cmd.fill    = !hit && (act_reg == ACT_PUT) && room;
        cmd.evict   = !hit && (act_reg == ACT_PUT) && !room;
        cmd.age_all = !hit;
        cmd.limit   = chain[ENTRIES].rank;
        cmd.occ_m1  = RANK_W'(occ_reg - OCC_W'(1));
        cmd.key     = key_reg;
        cmd.value   = val_reg;
    end

    assign chain[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lkvc_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE: state_next = accept ? ST_EXEC : ST_IDLE;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase

        cap_next   = cfg_wr_en ? cfg_wr_data : cap_reg;
        occ_next   = (exec && cmd.fill) ? occ_reg + OCC_W'(1) : occ_reg;
        done_next  = exec;
        found_next = hit;
        rdata_next = (hit && (act_reg == ACT_GET)) ? chain[ENTRIES].data : MISS_VALUE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= CAP_RESET;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            key_reg <= key;
            val_reg <= value;
        end
        if (exec)
        begin
            found_reg <= found_next;
            rdata_reg <= rdata_next;
        end
    end

    assign busy       = exec;
    assign done       = done_reg;
    assign found      = found_reg;
    assign read_value = rdata_reg;

endmodule

`default_nettype wire

>>> src/lkvc_cell.sv
// ----------------------------------------------------------------------------
// lkvc_cell: one cache entry
// Holds key, data, valid and recency rank; compares the broadcast key and
// hands hit, rank, data and free-slot status on to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_cell
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lkvc_pkg::cmd_t   cmd,
    input  wire lkvc_pkg::chain_t chain_in,
    output lkvc_pkg::chain_t      chain_out
);
    import lkvc_pkg::*;

    logic              valid_reg, valid_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [DATA_W-1:0] data_reg, data_next;

    logic match;
    logic sel_fill;
    logic sel_vict;
    logic slot;
    logic age;

    assign match    = valid_reg && (key_reg == cmd.key);
    assign sel_fill = !valid_reg && !chain_in.free_seen;
    assign sel_vict = valid_reg && (rank_reg == cmd.occ_m1);

    always_comb
    begin
        chain_out.free_seen = chain_in.free_seen | ~valid_reg;
        chain_out.hit       = chain_in.hit | match;
        chain_out.rank      = chain_in.rank | (match ? rank_reg : '0);
        chain_out.data      = chain_in.data | (match ? data_reg : '0);
    end

    always_comb
    begin
        if (cmd.hit)
        begin
            slot = cmd.exec & match;
        end
        else if (cmd.fill)
        begin
            slot = cmd.exec & sel_fill;
        end
        else if (cmd.evict)
        begin
            slot = cmd.exec & sel_vict;
        end
        else
        begin
            slot = 1'b0;
        end

        age = cmd.exec & valid_reg & ~slot & (cmd.hit | cmd.fill | cmd.evict)
              & (cmd.age_all | (rank_reg < cmd.limit));

        valid_next = valid_reg | (slot & cmd.fill);

        if (slot)
        begin
            rank_next = '0;
        end
        else if (age)
        begin
            rank_next = rank_reg + RANK_W'(1);
        end
        else
        begin
            rank_next = rank_reg;
        end

        key_next  = (slot & (cmd.fill | cmd.evict)) ? cmd.key : key_reg;
        data_next = (slot & cmd.put) ? cmd.value : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        data_reg <= data_next;
    end

endmodule

`default_nettype wire
